// ===== hdl/smsrng_pkg.sv =====
// ----------------------------------------------------------------------------
// smsrng_pkg
// Shared types and constants of the shuffled minimal-standard generator.
// ----------------------------------------------------------------------------
`default_nettype none

package smsrng_pkg;

    // generator constants, x' = MS_MULT * x mod MS_MOD
    localparam logic [14:0] MS_MULT = 15'd16807;
    localparam logic [30:0] MS_MOD  = 31'h7FFF_FFFF;

    // request kinds carried on s_tuser
    localparam logic REQ_DRAW   = 1'b0;
    localparam logic REQ_RESEED = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCALE,
        ST_READ,
        ST_DONE
    } smsrng_state_t;

endpackage

`default_nettype wire

// ===== hdl/shuffled_minimal_standard_rng_core.sv =====
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_rng_core
// Minimal-standard multiplicative generator with a shuffle table.
// ----------------------------------------------------------------------------
// One input word gives one output word. A draw passes from accept through
// ST_SCALE, ST_READ and ST_DONE before m_tvalid is set, and the next word is
// accepted only after the sequencer returns to ST_IDLE. A reseed, or the
// first draw after reset, first runs TABLE_SIZE + WARMUP_STEPS generator
// steps (40 at the defaults) in ST_INIT, one per cycle, before that draw.
// A single modular multiply unit (16807 * x mod 2^31-1, folded as high part
// plus low part with one conditional subtract) advances the seed once per
// cycle and is shared by initialization and draws. The block takes one word
// at a time: s_tready is high only while the sequencer is idle, and the
// sequencer holds its finished word until the previous output word has been
// taken. The slot is chosen from the previous output through a constant
// reciprocal multiply; the shuffle table is a TABLE_SIZE-deep memory with a
// registered read. There is no clearing pass: the table is always filled
// before it is read. The output is the integer in 1 .. 2^31-2; scaling to a
// real number is left to software.
`default_nettype none

module shuffled_minimal_standard_rng_core
    import smsrng_pkg::*;
#(
    parameter int TABLE_SIZE   = 32,
    parameter int WARMUP_STEPS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input word
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] seed_in, [31] zero
    input  wire logic [0:0]  s_tuser,   // [0] req_type
    // result word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [30:0] random_value, [31] zero
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + WARMUP_STEPS);
    localparam logic [CNT_W-1:0] INIT_LAST = CNT_W'(TABLE_SIZE + WARMUP_STEPS - 1);

    // slot = last / SLOT_DIV, done as (last * RECIP) >> SLOT_SHIFT, exact for 31 bits
    localparam logic [63:0] SLOT_DIV   = 64'd1 + (64'd2147483646 / TABLE_SIZE);
    localparam int          SLOT_LOG   = $clog2(SLOT_DIV);
    localparam int          SLOT_SHIFT = 31 + SLOT_LOG;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SLOT_SHIFT) + SLOT_DIV - 64'd1) / SLOT_DIV;
    localparam logic [31:0] RECIP      = RECIP_FULL[31:0];

    smsrng_state_t state_reg, state_next;
    logic [30:0]      lcg_reg, lcg_next;
    logic [30:0]      last_reg, last_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             out_valid_reg, out_valid_next;
    logic [30:0]      out_data_reg, out_data_next;
    logic [62:0]      prod_reg;
    logic [30:0]      rd_data_reg;

    logic [30:0] shuffle_table [TABLE_SIZE];

    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr;
    logic [30:0]      tbl_wdata;

    logic [45:0]      adv_prod;
    logic [31:0]      adv_sum;
    logic [30:0]      adv;
    logic [62:0]      slot_wide;
    logic [IDX_W-1:0] slot_calc;
    logic [30:0]      seed_clean;

    // shared modular multiply unit
    assign adv_prod = 46'(lcg_reg) * 46'(MS_MULT);
    assign adv_sum  = 32'(adv_prod[30:0]) + 32'(adv_prod[45:31]);
    assign adv      = (adv_sum >= 32'(MS_MOD)) ? 31'(adv_sum - 32'(MS_MOD)) : adv_sum[30:0];

    // slot from the reciprocal product
    assign slot_wide = prod_reg >> SLOT_SHIFT;
    assign slot_calc = (slot_wide >= 63'(TABLE_SIZE)) ? '0 : slot_wide[IDX_W-1:0];

    // zero seed and the modulus itself both start from 1
    assign seed_clean = (s_tdata[30:0] == 31'd0 || s_tdata[30:0] == MS_MOD)
                        ? 31'd1 : s_tdata[30:0];

    // reciprocal multiply, registered
    always_ff @(posedge aclk) begin
        prod_reg <= 63'(last_reg) * 63'(RECIP);
    end

    // shuffle table memory
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            shuffle_table[tbl_waddr] <= tbl_wdata;
        end
        if (state_reg == ST_READ) begin
            rd_data_reg <= shuffle_table[slot_calc];
        end
    end

    // sequencer and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            lcg_reg       <= '0;
            last_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lcg_reg       <= lcg_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        slot_reg     <= slot_next;
        out_data_reg <= out_data_next;
    end

    // next state and datapath control
    always_comb begin
        state_next     = state_reg;
        lcg_next       = lcg_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        tbl_we         = 1'b0;
        tbl_waddr      = slot_reg;
        tbl_wdata      = lcg_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == REQ_RESEED || last_reg == 31'd0) begin
                        lcg_next   = (s_tuser[0] == REQ_RESEED) ? seed_clean : 31'd1;
                        cnt_next   = INIT_LAST;
                        state_next = ST_INIT;
                    end else begin
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_INIT: begin
                // warm-up, then fill the table from the highest slot down
                lcg_next = adv;
                if (32'(cnt_reg) < 32'(TABLE_SIZE)) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = cnt_reg[IDX_W-1:0];
                    tbl_wdata = adv;
                end
                if (cnt_reg == '0) begin
                    last_next  = adv;
                    state_next = ST_SCALE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_SCALE: begin
                state_next = ST_READ;
            end
            ST_READ: begin
                slot_next  = slot_calc;
                lcg_next   = adv;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hand out the old entry and refill the slot
                if (!out_valid_reg || m_tready) begin
                    tbl_we         = 1'b1;
                    last_next      = rd_data_reg;
                    out_valid_next = 1'b1;
                    out_data_next  = rd_data_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    // checks
    a_read_then_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |=> state_reg == ST_DONE)
        else $error("table read not followed by refill");

    a_reseed_inits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == REQ_RESEED |=> state_reg == ST_INIT)
        else $error("reseed word did not start initialization");

    a_seed_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE && state_reg != ST_INIT |-> lcg_reg != 31'd0)
        else $error("generator seed stuck at zero");

    a_out_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[30:0] != 31'd0 && m_tdata[30:0] != MS_MOD)
        else $error("output word out of range");

endmodule

`default_nettype wire
